// ===== rtl/cpn_pkg.sv =====
// Shared constants for the collision pair narrow-phase unit.
package cpn_pkg;

    // Fixed-point format of all positions, radii and results
    localparam int FRAC_BITS = 16;

    // Square-root unit: 64-bit radicand, 32-bit root, one root bit per cycle
    localparam int RAD_W  = 64;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SCW    = $clog2(ROOT_W);

    // Divider: |n| < 2^33, quotient never exceeds 1.0 (FRAC_BITS + 1 bits)
    localparam int QW  = FRAC_BITS + 1;
    localparam int DVW = 33 + FRAC_BITS;
    localparam int DCW = $clog2(QW);

endpackage

// ===== rtl/cpn_sqrt.sv =====
// Bit-serial integer square root: two radicand bits in, one root bit out per cycle.
module cpn_sqrt import cpn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]  r_x;
    logic [ROOT_W:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SCW-1:0]    r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W+2:0] w_rem_sh;
    logic [ROOT_W+2:0] w_trial;
    logic              w_ge;

    // one restoring step
    always_comb begin
        w_rem_sh = {r_rem, r_x[RAD_W-1 -: 2]};
        w_trial  = {1'b0, r_root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SCW'(ROOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? (ROOT_W+1)'(w_rem_sh - w_trial) : (ROOT_W+1)'(w_rem_sh);
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/cpn_div.sv =====
// Bit-serial restoring divider producing the normal component quotient.
module cpn_div import cpn_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_dividend,
    input  logic [31:0]    i_divisor,
    output logic           o_done,
    output logic [QW-1:0]  o_quot
);

    logic [31:0]    r_rem;
    logic [QW-1:0]  r_lo;
    logic [QW-1:0]  r_q;
    logic [31:0]    r_dvs;
    logic [DCW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [32:0]    w_rsh;
    logic           w_ge;

    // one quotient bit per cycle
    always_comb begin
        w_rsh = {r_rem, r_lo[QW-1]};
        w_ge  = (w_rsh >= {1'b0, r_dvs});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCW'(QW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // high part of the dividend is known to be below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVW-1:QW];
            r_lo  <= i_dividend[QW-1:0];
            r_q   <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_rsh - {1'b0, r_dvs}) : w_rsh[31:0];
            r_lo  <= {r_lo[QW-2:0], 1'b0};
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/collision_pair_narrowphase_unit.sv =====
// Collision pair narrow-phase unit: sphere/box overlap test with contact normal and depth.
// A request with second_of_pair low stores body A and gives no result. A request with
// second_of_pair high takes body B and gives one result. A skipped pair (both static) goes
// straight to the finish state; a box-box pair ends after the centre, offset, vector, clamp
// and select stages. Pairs with a sphere then go through a squaring pass on a single 32x32
// multiplier (three vector lanes, then the radius sum); missing pairs end there. Hits then
// run a bit-serial square root, which ends the work for box-sphere hits and coincident
// sphere centers. Other sphere-sphere hits add three parallel bit-serial divisions of
// FRAC_BITS+1 quotient bits. One pair is processed at a time; a finished result sits in an
// output register, so the next request is taken while it waits.
module collision_pair_narrowphase_unit import cpn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_second_of_pair,
    input  logic               i_kind,
    input  logic               i_is_fixed,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [30:0]        i_radius,
    input  logic signed [31:0] i_box_min_x,
    input  logic signed [31:0] i_box_min_y,
    input  logic signed [31:0] i_box_min_z,
    input  logic signed [31:0] i_box_max_x,
    input  logic signed [63:0] i_box_max_yz,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic               o_both_static,
    output logic signed [31:0] o_normal_x,
    output logic signed [31:0] o_normal_y,
    output logic signed [31:0] o_normal_z,
    output logic signed [31:0] o_depth
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_CEN  = 11'b000_0000_0010,
        S_OFS  = 11'b000_0000_0100,
        S_VEC  = 11'b000_0000_1000,
        S_CLMP = 11'b000_0001_0000,
        S_SEL  = 11'b000_0010_0000,
        S_SQ   = 11'b000_0100_0000,
        S_CMP  = 11'b000_1000_0000,
        S_ROOT = 11'b001_0000_0000,
        S_DIV  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } t_state;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic signed [31:0] ONE     = 32'(1 << FRAC_BITS);
    localparam logic signed [31:0] NEG_ONE = -ONE;

    function automatic logic [31:0] f_sat32(input logic signed [39:0] v);
        logic [31:0] res;
        if (v > 40'sh00_7FFF_FFFF) begin
            res = 32'h7FFF_FFFF;
        end else if (v < 40'shFF_8000_0000) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    t_state r_state;

    // stored body A and captured body B
    logic               r_a_kind, r_a_fixed;
    logic signed [31:0] r_a_pos[3], r_a_min[3], r_a_max[3];
    logic [30:0]        r_a_rad;
    logic               r_b_kind;
    logic signed [31:0] r_b_pos[3], r_b_min[3], r_b_max[3];
    logic [30:0]        r_b_rad;

    // per-axis working registers
    logic signed [31:0] r_ca[3], r_ea[3], r_cb[3], r_eb[3];
    logic signed [32:0] r_pa[3], r_pb[3], r_e[3];
    logic signed [34:0] r_n[3];
    logic [34:0]        r_abs[3];
    logic signed [35:0] r_t[3];
    logic signed [35:0] r_v[3];
    logic [2:0]         r_in;

    logic [31:0]        r_rsum;
    logic               r_inside;
    logic [1:0]         r_sqc;
    logic [63:0]        r_prod;
    logic               r_psat;
    logic [63:0]        r_dsq;

    // pending result and output register
    logic               r_res_hit, r_res_static;
    logic signed [31:0] r_res_nrm[3];
    logic signed [31:0] r_res_dep;
    logic               r_ovalid;
    logic               r_o_hit, r_o_static;
    logic signed [31:0] r_o_nrm[3];
    logic signed [31:0] r_o_dep;

    logic               w_in_acc, w_oload;
    logic               w_ss, w_bb, w_bs, w_sb, w_boxsph;
    logic signed [32:0] w_suma[3], w_difa[3], w_sumb[3], w_difb[3];
    logic signed [32:0] w_pa[3], w_pb[3], w_e[3];
    logic signed [33:0] w_d[3];
    logic signed [34:0] w_n[3], w_lo[3], w_hi[3], w_c1[3], w_c2[3];
    logic [34:0]        w_absn[3];
    logic signed [35:0] w_e36[3], w_ov[3], w_clp[3], w_diff[3];
    logic [1:0]         w_axo, w_axb;
    logic               w_inside, w_bb_hit, w_sph_hit;
    logic signed [35:0] w_tsel;
    logic               w_nneg;
    logic signed [35:0] w_vsel;
    logic [35:0]        w_vabs;
    logic [31:0]        w_mop;
    logic               w_msat;
    logic [64:0]        w_acc;
    logic               w_sq_start, w_sq_done;
    logic [ROOT_W-1:0]  w_root;
    logic signed [33:0] w_dep_raw;
    logic               w_dv_start;
    logic [2:0]         w_dv_done;
    logic [QW-1:0]      w_q[3];

    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && !o_stall;
    assign w_oload  = (r_state == S_FIN) && (!r_ovalid || !i_stall);

    // pair type
    assign w_ss     = !r_a_kind && !r_b_kind;
    assign w_bb     = r_a_kind && r_b_kind;
    assign w_bs     = r_a_kind && !r_b_kind;
    assign w_sb     = !r_a_kind && r_b_kind;
    assign w_boxsph = w_bs || w_sb;

    // per-axis geometry
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_suma[k] = 33'(r_a_min[k]) + 33'(r_a_max[k]);
            w_difa[k] = 33'(r_a_max[k]) - 33'(r_a_min[k]);
            w_sumb[k] = 33'(r_b_min[k]) + 33'(r_b_max[k]);
            w_difb[k] = 33'(r_b_max[k]) - 33'(r_b_min[k]);
            w_pa[k]   = 33'(r_a_pos[k]) + (r_a_kind ? 33'(r_ca[k]) : 33'sd0);
            w_pb[k]   = 33'(r_b_pos[k]) + (r_b_kind ? 33'(r_cb[k]) : 33'sd0);
            if (w_bb) begin
                w_e[k] = 33'(r_ea[k]) + 33'(r_eb[k]);
            end else if (w_sb) begin
                w_e[k] = 33'(r_eb[k]);
            end else begin
                w_e[k] = 33'(r_ea[k]);
            end
            w_d[k]    = 34'(r_pb[k]) - 34'(r_pa[k]);
            w_n[k]    = w_sb ? -35'(w_d[k]) : 35'(w_d[k]);
            w_absn[k] = r_n[k][34] ? 35'(-r_n[k]) : 35'(r_n[k]);
            w_e36[k]  = 36'(r_e[k]);
            w_ov[k]   = w_e36[k] - $signed({1'b0, w_absn[k]});
            w_hi[k]   = 35'(r_e[k]);
            w_lo[k]   = -w_hi[k];
            w_c1[k]   = (r_n[k] < w_lo[k]) ? w_lo[k] : r_n[k];
            w_c2[k]   = (w_c1[k] > w_hi[k]) ? w_hi[k] : w_c1[k];
        end
    end

    // axis of smallest box overlap (a tie for smallest selects Z)
    always_comb begin
        priority if (r_t[0] < r_t[1] && r_t[0] < r_t[2]) begin
            w_axo = AX_X;
        end else if (r_t[1] < r_t[0] && r_t[1] < r_t[2]) begin
            w_axo = AX_Y;
        end else begin
            w_axo = AX_Z;
        end
    end

    // axis of largest sphere offset (a tie for largest selects Z)
    always_comb begin
        priority if (r_abs[0] > r_abs[1] && r_abs[0] > r_abs[2]) begin
            w_axb = AX_X;
        end else if (r_abs[1] > r_abs[0] && r_abs[1] > r_abs[2]) begin
            w_axb = AX_Y;
        end else begin
            w_axb = AX_Z;
        end
    end

    assign w_inside = &r_in;
    assign w_bb_hit = !(r_t[0] <= 36'sd0 || r_t[1] < 36'sd0 || r_t[2] < 36'sd0);

    always_comb begin
        unique case (w_axo)
            AX_X: begin w_tsel = r_t[0]; w_nneg = r_n[0][34]; end
            AX_Y: begin w_tsel = r_t[1]; w_nneg = r_n[1][34]; end
            default: begin w_tsel = r_t[2]; w_nneg = r_n[2][34]; end
        endcase
    end

    // clamped point, pushed to the face when the center is inside, then offset from it
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_clp[k]  = (w_inside && w_axb == 2'(k)) ?
                        ((r_t[k] > 36'sd0) ? w_e36[k] : -w_e36[k]) : r_t[k];
            w_diff[k] = 36'(r_n[k]) - w_clp[k];
        end
    end

    // squaring operand: three vector lanes then the radius sum
    always_comb begin
        unique case (r_sqc)
            2'd0:    w_vsel = r_v[0];
            2'd1:    w_vsel = r_v[1];
            2'd2:    w_vsel = r_v[2];
            default: w_vsel = 36'sd0;
        endcase
        w_vabs = w_vsel[35] ? 36'(-w_vsel) : 36'(w_vsel);
        if (r_sqc == 2'd3) begin
            w_mop  = r_rsum;
            w_msat = 1'b0;
        end else begin
            w_mop  = w_vabs[31:0];
            w_msat = |w_vabs[35:32];
        end
        w_acc = {1'b0, r_dsq} + {1'b0, r_prod};
    end

    assign w_sph_hit  = (r_dsq <= r_prod) || (w_boxsph && r_inside);
    assign w_sq_start = (r_state == S_CMP) && w_sph_hit;
    assign w_dv_start = (r_state == S_ROOT) && w_sq_done && w_ss && (w_root != '0);
    assign w_dep_raw  = $signed({2'b00, r_rsum}) - $signed({2'b00, w_root});

    cpn_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (r_dsq),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div
        cpn_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (w_dv_start),
            .i_dividend ({w_absn[g][32:0], {FRAC_BITS{1'b0}}}),
            .i_divisor  (w_root),
            .o_done     (w_dv_done[g]),
            .o_quot     (w_q[g])
        );
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_second_of_pair) begin
                        r_state <= (r_a_fixed && i_is_fixed) ? S_FIN : S_CEN;
                    end
                end
                S_CEN:  r_state <= S_OFS;
                S_OFS:  r_state <= S_VEC;
                S_VEC:  r_state <= S_CLMP;
                S_CLMP: r_state <= S_SEL;
                S_SEL:  r_state <= w_bb ? S_FIN : S_SQ;
                S_SQ:   if (r_sqc == 2'd3) r_state <= S_CMP;
                S_CMP:  r_state <= w_sph_hit ? S_ROOT : S_FIN;
                S_ROOT: begin
                    if (w_sq_done) begin
                        r_state <= w_dv_start ? S_DIV : S_FIN;
                    end
                end
                S_DIV:  if (w_dv_done[0]) r_state <= S_FIN;
                S_FIN:  if (w_oload) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // stored body A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_kind  <= 1'b0;
            r_a_fixed <= 1'b0;
            r_a_rad   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_a_pos[k] <= '0;
                r_a_min[k] <= '0;
                r_a_max[k] <= '0;
            end
        end else if (w_in_acc && !i_second_of_pair) begin
            r_a_kind   <= i_kind;
            r_a_fixed  <= i_is_fixed;
            r_a_rad    <= i_radius;
            r_a_pos[0] <= i_pos_x;
            r_a_pos[1] <= i_pos_y;
            r_a_pos[2] <= i_pos_z;
            r_a_min[0] <= i_box_min_x;
            r_a_min[1] <= i_box_min_y;
            r_a_min[2] <= i_box_min_z;
            r_a_max[0] <= i_box_max_x;
            r_a_max[1] <= i_box_max_yz[63:32];
            r_a_max[2] <= i_box_max_yz[31:0];
        end
    end

    // body B capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_second_of_pair) begin
            r_b_kind   <= i_kind;
            r_b_rad    <= i_radius;
            r_b_pos[0] <= i_pos_x;
            r_b_pos[1] <= i_pos_y;
            r_b_pos[2] <= i_pos_z;
            r_b_min[0] <= i_box_min_x;
            r_b_min[1] <= i_box_min_y;
            r_b_min[2] <= i_box_min_z;
            r_b_max[0] <= i_box_max_x;
            r_b_max[1] <= i_box_max_yz[63:32];
            r_b_max[2] <= i_box_max_yz[31:0];
        end
    end

    // geometry stages
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (r_state == S_CEN) begin
                r_ca[k] <= w_suma[k][32:1];
                r_ea[k] <= w_difa[k][32:1];
                r_cb[k] <= w_sumb[k][32:1];
                r_eb[k] <= w_difb[k][32:1];
            end
            if (r_state == S_OFS) begin
                r_pa[k] <= w_pa[k];
                r_pb[k] <= w_pb[k];
                r_e[k]  <= w_e[k];
            end
            if (r_state == S_VEC) begin
                r_n[k] <= w_n[k];
            end
            if (r_state == S_CLMP) begin
                r_abs[k] <= w_absn[k];
                r_t[k]   <= w_bb ? w_ov[k] : 36'(w_c2[k]);
                r_in[k]  <= (w_c2[k] == r_n[k]);
            end
            if (r_state == S_SEL) begin
                r_v[k] <= w_ss ? 36'(r_n[k]) : w_diff[k];
            end
        end
        if (r_state == S_VEC) begin
            if (w_ss) begin
                r_rsum <= 32'(r_a_rad) + 32'(r_b_rad);
            end else if (w_bs) begin
                r_rsum <= 32'(r_b_rad);
            end else begin
                r_rsum <= 32'(r_a_rad);
            end
        end
        if (r_state == S_SEL) begin
            r_inside <= w_inside;
        end
    end

    // squared distance and squared radius through one multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqc <= '0;
        end else if (r_state == S_SQ) begin
            r_sqc <= r_sqc + 1'b1;
        end else begin
            r_sqc <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SQ) begin
            r_prod <= w_mop * w_mop;
            r_psat <= w_msat;
            if (r_sqc != 2'd0) begin
                r_dsq <= (r_psat || w_acc[64]) ? '1 : w_acc[63:0];
            end
        end else if (r_state == S_SEL) begin
            r_dsq <= '0;
        end
    end

    // result assembly
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_second_of_pair) begin
            r_res_hit    <= 1'b0;
            r_res_static <= r_a_fixed && i_is_fixed;
            r_res_dep    <= '0;
            for (int k = 0; k < 3; k++) r_res_nrm[k] <= '0;
        end
        if (r_state == S_SEL && w_bb && w_bb_hit) begin
            r_res_hit <= 1'b1;
            r_res_dep <= f_sat32(40'(w_tsel));
            for (int k = 0; k < 3; k++) begin
                r_res_nrm[k] <= (w_axo == 2'(k)) ? (w_nneg ? NEG_ONE : ONE) : 32'sd0;
            end
        end
        if (r_state == S_ROOT && w_sq_done) begin
            r_res_hit <= 1'b1;
            if (w_ss && w_root == '0) begin
                r_res_dep    <= 32'(r_a_rad);
                r_res_nrm[0] <= ONE;
            end else begin
                r_res_dep <= f_sat32(40'(w_dep_raw));
            end
            if (w_boxsph) begin
                for (int k = 0; k < 3; k++) begin
                    r_res_nrm[k] <= f_sat32((r_inside ^ w_sb) ? -40'(r_n[k]) : 40'(r_n[k]));
                end
            end
        end
        if (r_state == S_DIV && w_dv_done[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_res_nrm[k] <= r_n[k][34] ? -32'(w_q[k]) : 32'(w_q[k]);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oload) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_o_hit    <= r_res_hit;
            r_o_static <= r_res_static;
            r_o_dep    <= r_res_dep;
            for (int k = 0; k < 3; k++) r_o_nrm[k] <= r_res_nrm[k];
        end
    end

    assign o_valid       = r_ovalid;
    assign o_hit         = r_o_hit;
    assign o_both_static = r_o_static;
    assign o_normal_x    = r_o_nrm[0];
    assign o_normal_y    = r_o_nrm[1];
    assign o_normal_z    = r_o_nrm[2];
    assign o_depth       = r_o_dep;

`ifndef SYNTH
    // the root unit only finishes while the sequencer waits for it
    a_root_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (r_state == S_ROOT))
        else $error("square root finished outside root wait");

    // the dividers only finish while the sequencer waits for them
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_dv_done) |-> (r_state == S_DIV))
        else $error("divider finished outside divide wait");

    // a skipped pair never reports contact
    a_static_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_both_static) |-> (!o_hit && o_depth == 32'sd0))
        else $error("static pair reported contact");
`endif

endmodule
